FILE: rtl/core/smks_pkg.sv
// Package of shared constants, types and helpers for the sticky modifier key scanner.
package smks_pkg;

  localparam int KEY_GROUPS     = 7;
  localparam int MODIFIER_COUNT = 4;
  localparam int NUM_KEYS       = KEY_GROUPS * 8;

  // Fixed field widths of the scan and result beats.
  localparam int MATRIX_W   = 56;
  localparam int LEVEL_BITS = 4;
  localparam int LEVEL_IDX_W = 2;
  localparam int MASK_W     = 4;
  localparam int CODE_W     = 6;

  // Key numbers that belong to the modifier keys and are never reported.
  localparam int MOD_KEY_2ND   = 40;
  localparam int MOD_KEY_ALPHA = 48;
  localparam int MOD_KEY_MODE  = 54;
  localparam int MOD_KEY_GRAPH = 55;

  typedef logic [NUM_KEYS-1:0] key_vec_t;

  typedef struct packed {
    logic              found;
    logic [CODE_W-1:0] code;
  } key_result_t;

  function automatic key_vec_t mod_position_mask();
    key_vec_t m;
    m = '0;
    for (int k = 0; k < NUM_KEYS; k++) begin
      m[k] = (k + 1 == MOD_KEY_2ND) || (k + 1 == MOD_KEY_ALPHA) ||
             (k + 1 == MOD_KEY_MODE) || (k + 1 == MOD_KEY_GRAPH);
    end
    return m;
  endfunction

  localparam key_vec_t MOD_POS_MASK = mod_position_mask();

  // Level of modifier i; modifiers without a level bit read as released.
  function automatic logic level_of(logic [LEVEL_BITS-1:0] down, int i);
    logic lv;
    lv = 1'b0;
    if (i < LEVEL_BITS) begin
      lv = down[i[LEVEL_IDX_W-1:0]];
    end
    return lv;
  endfunction

endpackage

FILE: rtl/core/smks_if.sv
// Handshake interfaces for the scan and result channels.
interface smks_scan_if import smks_pkg::*; ;
  logic                  valid;
  logic                  ready;
  logic [MATRIX_W-1:0]   key_matrix;
  logic [LEVEL_BITS-1:0] modifier_down;

  modport source (output valid, output key_matrix, output modifier_down, input ready);
  modport sink   (input valid, input key_matrix, input modifier_down, output ready);
endinterface

interface smks_result_if import smks_pkg::*; ;
  logic              valid;
  logic              ready;
  logic [MASK_W-1:0] shift_mask;
  logic [CODE_W-1:0] key_code;

  modport source (output valid, output shift_mask, output key_code, input ready);
  modport sink   (input valid, input shift_mask, input key_code, output ready);
endinterface

FILE: rtl/core/smks_mod_fsm.sv
// Sticky state machines for the modifier keys and the mask taken from them.
module smks_mod_fsm import smks_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  step,
  input  logic [LEVEL_BITS-1:0] down,
  input  logic                  key_found,
  output logic [MASK_W-1:0]     mask
);

  typedef enum logic [1:0] {
    MOD_OFF     = 2'd0,
    MOD_NEW     = 2'd1,
    MOD_LATCHED = 2'd2,
    MOD_KEPT    = 2'd3
  } mod_state_t;

  mod_state_t state      [MODIFIER_COUNT];
  mod_state_t state_next [MODIFIER_COUNT];

  always_comb begin
    for (int i = 0; i < MODIFIER_COUNT; i++) begin
      logic lv;
      mod_state_t s;
      lv = level_of(down, i);
      s  = state[i];
      case (state[i])
        MOD_OFF:     s = lv ? MOD_NEW : MOD_OFF;
        MOD_NEW:     s = lv ? MOD_NEW : MOD_LATCHED;
        MOD_LATCHED: s = lv ? MOD_KEPT : MOD_LATCHED;
        MOD_KEPT:    s = lv ? MOD_KEPT : MOD_OFF;
        default:     s = MOD_OFF;
      endcase
      // A reported key consumes any pending sticky modifier.
      if (key_found && (s == MOD_NEW || s == MOD_LATCHED)) begin
        s = lv ? MOD_KEPT : MOD_OFF;
      end
      state_next[i] = s;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < MODIFIER_COUNT; i++) begin
      if (rst) begin
        state[i] <= MOD_OFF;
      end else if (step) begin
        state[i] <= state_next[i];
      end
    end
  end

  always_comb begin
    mask = '0;
    for (int i = 0; i < MASK_W; i++) begin
      if (i < MODIFIER_COUNT) begin
        mask[i] = (state[i] != MOD_OFF);
      end
    end
  end

endmodule

FILE: rtl/core/smks_key_enc.sv
// New-press priority encoder with the per-key previous-press register.
module smks_key_enc import smks_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  logic                step,
  input  logic [MATRIX_W-1:0] key_matrix,
  output key_result_t         result
);

  key_vec_t previous_pressed;
  key_vec_t previous_pressed_next;
  key_vec_t pressed;
  key_vec_t fresh;
  key_vec_t lowest;
  key_vec_t below;

  assign pressed = NUM_KEYS'(key_matrix);
  assign fresh   = pressed & ~previous_pressed & ~MOD_POS_MASK;
  assign lowest  = fresh & (~fresh + key_vec_t'(1));
  // All ones when no key is new, so every bit gets updated then.
  assign below   = lowest - key_vec_t'(1);

  assign previous_pressed_next = (previous_pressed & pressed & below) | lowest |
                                 (previous_pressed & ~below & ~lowest);

  always_comb begin
    result.found = |lowest;
    result.code  = '0;
    for (int k = 0; k < NUM_KEYS; k++) begin
      if (lowest[k]) begin
        result.code = result.code | CODE_W'(k + 1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      previous_pressed <= '0;
    end else if (step) begin
      previous_pressed <= previous_pressed_next;
    end
  end

endmodule

FILE: rtl/core/sticky_modifier_key_scanner.sv
// Top level of the sticky modifier key scanner: scan register, encoder, modifiers, result register.
//
//   channel   dir   beat contents
//   -------   ---   --------------------------------------------
//   scan      in    key_matrix (56 b), modifier_down (4 b)
//   result    out   shift_mask (4 b), key_code (6 b, 0 = no new key)
//
// A scan beat is taken into the scan register, is worked on between the two
// registers and is written into the result register once that register is free or
// being drained, which raises result.valid. One scan is accepted every cycle while
// the result channel does not stall, limited only by the encode of the lowest new
// key across the matrix between the two registers.
// Reset is synchronous: both registers empty, modifiers clear, no key held.
// When the result waits, the scan register holds its beat and scan.ready falls
// only once that register is full too.
module sticky_modifier_key_scanner import smks_pkg::*; (
  input  logic           clk,
  input  logic           rst,
  smks_scan_if.sink      scan,
  smks_result_if.source  result
);

  // Scan register.
  logic                  in_full;
  logic [MATRIX_W-1:0]   in_matrix;
  logic [LEVEL_BITS-1:0] in_down;

  // Result register.
  logic              out_full;
  logic [MASK_W-1:0] out_mask;
  logic [CODE_W-1:0] out_code;

  logic              advance;
  logic [MASK_W-1:0] mask;
  key_result_t       key_res;

  // The buffered scan moves on whenever the result register is free or being drained.
  assign advance    = in_full && (!out_full || result.ready);
  assign scan.ready = !in_full || advance;

  // The mask comes from the modifier states before this scan steps them.
  smks_mod_fsm u_mod (
    .clk       (clk),
    .rst       (rst),
    .step      (advance),
    .down      (in_down),
    .key_found (key_res.found),
    .mask      (mask)
  );

  smks_key_enc u_enc (
    .clk        (clk),
    .rst        (rst),
    .step       (advance),
    .key_matrix (in_matrix),
    .result     (key_res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (scan.valid && scan.ready) begin
      in_full <= 1'b1;
    end else if (advance) begin
      in_full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (scan.valid && scan.ready) begin
      in_matrix <= scan.key_matrix;
      in_down   <= scan.modifier_down;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_full <= 1'b0;
    end else if (advance) begin
      out_full <= 1'b1;
    end else if (result.ready) begin
      out_full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_mask <= mask;
      out_code <= key_res.code;
    end
  end

  assign result.valid      = out_full;
  assign result.shift_mask = out_mask;
  assign result.key_code   = out_code;

endmodule

FILE: rtl/core/smks_checker.sv
// Port-level checks for the sticky modifier key scanner, bound to its top level.
module smks_checker import smks_pkg::*; (
  input logic              clk,
  input logic              rst,
  input logic              out_valid,
  input logic              out_ready,
  input logic [MASK_W-1:0] shift_mask,
  input logic [CODE_W-1:0] key_code
);

  logic              seen;
  logic [CODE_W-1:0] last_code;

  always_ff @(posedge clk) begin
    if (rst) begin
      seen <= 1'b0;
    end else if (out_valid && out_ready) begin
      seen <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (out_valid && out_ready) begin
      last_code <= key_code;
    end
  end

  a_code_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> key_code <= CODE_W'(NUM_KEYS))
    else $error("key_code beyond key count");

  a_no_mod_key: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (key_code != CODE_W'(MOD_KEY_2ND)) && (key_code != CODE_W'(MOD_KEY_ALPHA)) &&
                  (key_code != CODE_W'(MOD_KEY_MODE)) && (key_code != CODE_W'(MOD_KEY_GRAPH)))
    else $error("modifier key position reported as key");

  // A key must be released in some scan before it can be reported again.
  a_no_repeat: assert property (@(posedge clk) disable iff (rst)
    (out_valid && seen && key_code != '0) |-> key_code != last_code)
    else $error("same key reported in consecutive results");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> out_valid && $stable(key_code) && $stable(shift_mask))
    else $error("stalled result beat changed");

endmodule

bind sticky_modifier_key_scanner smks_checker u_smks_checker (
  .clk        (clk),
  .rst        (rst),
  .out_valid  (result.valid),
  .out_ready  (result.ready),
  .shift_mask (result.shift_mask),
  .key_code   (result.key_code)
);
